// ===== hw/rtl/running_median_defines.svh =====
// Assertion macros for the running median block.
`ifndef RUNNING_MEDIAN_DEFINES_SVH
`define RUNNING_MEDIAN_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("running_median check failed");
`define RM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("running_median check failed");
`else
`define RM_ASSERT_SAME(label, ante, cons)
`define RM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/rm_pkg.sv =====
// Shared constants, types and helpers of the running median block.
package rm_pkg;

    localparam int CAPACITY   = 1024;
    localparam int HEAP_DEPTH = (CAPACITY + 1) / 2;
    localparam int HEAP_AW    = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CNT_W      = HEAP_AW + 1;
    localparam int SAMPLE_W   = 32;
    localparam int MED_W      = 33;
    localparam int HELD_W     = 11;
    localparam int OUT_DATA_W = 48;

    localparam logic HEAP_LO = 1'b0;
    localparam logic HEAP_UP = 1'b1;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_DECIDE,
        OP_SD_CHK,
        OP_SD_RDB,
        OP_SD_CMP,
        OP_PU_START,
        OP_PU_CHK,
        OP_PU_CMP,
        OP_FINISH
    } rm_op_t;

    typedef struct packed {
        rm_op_t op;
    } rm_cmd_t;

    typedef struct packed {
        logic full;
        logic replace;
        logic sd_leaf;
        logic sd_move;
        logic pu_root;
        logic pu_move;
    } rm_stat_t;

    // a belongs above b: max-heap for the lower half, min-heap for the upper
    function automatic logic rm_above(logic signed [SAMPLE_W-1:0] a,
                                      logic signed [SAMPLE_W-1:0] b,
                                      logic is_upper);
        return is_upper ? (a < b) : (a > b);
    endfunction

endpackage

// ===== hw/rtl/rm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]              wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/rm_ctrl.sv =====
// Running median sequencer: one heap datapath step a cycle between handshakes.
module rm_ctrl
    import rm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output rm_cmd_t  cmd,
    input  rm_stat_t stat
);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_DECIDE   = 10'b00_0000_0010,
        ST_SD_CHK   = 10'b00_0000_0100,
        ST_SD_RDB   = 10'b00_0000_1000,
        ST_SD_CMP   = 10'b00_0001_0000,
        ST_PU_START = 10'b00_0010_0000,
        ST_PU_CHK   = 10'b00_0100_0000,
        ST_PU_CMP   = 10'b00_1000_0000,
        ST_FINISH   = 10'b01_0000_0000,
        ST_OUT      = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_IDLE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.op = OP_DECIDE;
                priority if (stat.full)
                    state_next = ST_FINISH;
                else if (stat.replace)
                    state_next = ST_SD_CHK;
                else
                    state_next = ST_PU_START;
            end
            ST_SD_CHK:
            begin
                cmd.op     = OP_SD_CHK;
                state_next = stat.sd_leaf ? ST_PU_START : ST_SD_RDB;
            end
            ST_SD_RDB:
            begin
                cmd.op     = OP_SD_RDB;
                state_next = ST_SD_CMP;
            end
            ST_SD_CMP:
            begin
                cmd.op     = OP_SD_CMP;
                state_next = stat.sd_move ? ST_SD_CHK : ST_PU_START;
            end
            ST_PU_START:
            begin
                cmd.op     = OP_PU_START;
                state_next = ST_PU_CHK;
            end
            ST_PU_CHK:
            begin
                cmd.op     = OP_PU_CHK;
                state_next = stat.pu_root ? ST_FINISH : ST_PU_CMP;
            end
            ST_PU_CMP:
            begin
                cmd.op     = OP_PU_CMP;
                state_next = stat.pu_move ? ST_PU_CHK : ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.op     = OP_FINISH;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/rm_dpath.sv =====
// Heap datapath: two heap RAMs, counts, cached tops, sift registers, result word.
module rm_dpath
    import rm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SAMPLE_W-1:0] sample_in,
    input  rm_cmd_t             cmd,
    output rm_stat_t            stat,
    output logic [MED_W-1:0]    med_out,
    output logic [HELD_W-1:0]   held_out,
    output logic                dropped_out
);

    logic [CNT_W-1:0]           lo_cnt_reg, lo_cnt_next;
    logic [CNT_W-1:0]           up_cnt_reg, up_cnt_next;
    logic signed [MED_W-1:0]    med_reg, med_next;

    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic signed [SAMPLE_W-1:0] val_reg, val_next;
    logic signed [SAMPLE_W-1:0] ca_reg, ca_next;
    logic signed [SAMPLE_W-1:0] pu_val_reg, pu_val_next;
    logic signed [SAMPLE_W-1:0] lo_top_reg, lo_top_next;
    logic signed [SAMPLE_W-1:0] up_top_reg, up_top_next;
    logic                       pu_heap_reg, pu_heap_next;
    logic                       heap_sel_reg, heap_sel_next;
    logic [HEAP_AW-1:0]         idx_reg, idx_next;
    logic                       drop_reg, drop_next;
    logic [MED_W-1:0]           med_out_reg, med_out_next;
    logic [HELD_W-1:0]          held_out_reg, held_out_next;
    logic                       drop_out_reg, drop_out_next;

    logic                       ram_we;
    logic [HEAP_AW-1:0]         ram_waddr;
    logic [SAMPLE_W-1:0]        ram_wdata;
    logic [HEAP_AW-1:0]         ram_raddr;
    logic [SAMPLE_W-1:0]        lo_rdata, up_rdata;
    logic signed [SAMPLE_W-1:0] rdata;

    logic [CNT_W:0]             held_sum;
    logic signed [MED_W-1:0]    x2;
    logic                       gt, lt;
    logic                       rep, sd_heap, pu_heap;
    logic signed [SAMPLE_W-1:0] pu_val;
    logic [CNT_W-1:0]           n_sel;
    logic [CNT_W:0]             c_idx, c1_idx;
    logic                       b_ok, take_b;
    logic signed [SAMPLE_W-1:0] pick;
    logic [HEAP_AW-1:0]         pick_idx;
    logic [HEAP_AW-1:0]         parent;
    logic signed [MED_W-1:0]    top_sum;

    rm_ram #(.WIDTH(SAMPLE_W), .DEPTH(HEAP_DEPTH)) u_lo_ram (
        .clk   (clk),
        .we    (ram_we && (heap_sel_reg == HEAP_LO)),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (lo_rdata)
    );

    rm_ram #(.WIDTH(SAMPLE_W), .DEPTH(HEAP_DEPTH)) u_up_ram (
        .clk   (clk),
        .we    (ram_we && (heap_sel_reg == HEAP_UP)),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (up_rdata)
    );

    assign rdata = (heap_sel_reg == HEAP_UP) ? up_rdata : lo_rdata;

    // insert decision
    assign held_sum = {1'b0, lo_cnt_reg} + {1'b0, up_cnt_reg};
    assign x2       = {x_reg, 1'b0};
    assign gt       = x2 > med_reg;
    assign lt       = x2 < med_reg;

    always_comb
    begin
        priority if (lo_cnt_reg == up_cnt_reg)
        begin
            rep     = 1'b0;
            sd_heap = HEAP_LO;
            pu_heap = gt ? HEAP_UP : HEAP_LO;
            pu_val  = x_reg;
        end
        else if (lo_cnt_reg < up_cnt_reg)
        begin
            // push into upper then pop its top equals swapping x with the top
            rep     = gt && (x_reg > up_top_reg);
            sd_heap = HEAP_UP;
            pu_heap = HEAP_LO;
            pu_val  = rep ? up_top_reg : x_reg;
        end
        else
        begin
            rep     = lt && (x_reg < lo_top_reg);
            sd_heap = HEAP_LO;
            pu_heap = HEAP_UP;
            pu_val  = rep ? lo_top_reg : x_reg;
        end
    end

    // sift engine
    assign n_sel    = (heap_sel_reg == HEAP_UP) ? up_cnt_reg : lo_cnt_reg;
    assign c_idx    = (CNT_W+1)'({idx_reg, 1'b1});
    assign c1_idx   = c_idx + 1'b1;
    assign b_ok     = c1_idx < {1'b0, n_sel};
    assign take_b   = b_ok && rm_above(rdata, ca_reg, heap_sel_reg);
    assign pick     = take_b ? rdata : ca_reg;
    assign pick_idx = take_b ? c1_idx[HEAP_AW-1:0] : c_idx[HEAP_AW-1:0];
    assign parent   = (idx_reg - 1'b1) >> 1;
    assign top_sum  = {lo_top_reg[SAMPLE_W-1], lo_top_reg}
                    + {up_top_reg[SAMPLE_W-1], up_top_reg};

    assign stat.full    = held_sum >= (CNT_W+1)'(CAPACITY);
    assign stat.replace = rep;
    assign stat.sd_leaf = c_idx >= {1'b0, n_sel};
    assign stat.sd_move = rm_above(pick, val_reg, heap_sel_reg);
    assign stat.pu_root = (idx_reg == '0);
    assign stat.pu_move = rm_above(val_reg, rdata, heap_sel_reg);

    always_comb
    begin
        lo_cnt_next   = lo_cnt_reg;
        up_cnt_next   = up_cnt_reg;
        med_next      = med_reg;
        x_next        = x_reg;
        val_next      = val_reg;
        ca_next       = ca_reg;
        pu_val_next   = pu_val_reg;
        pu_heap_next  = pu_heap_reg;
        heap_sel_next = heap_sel_reg;
        idx_next      = idx_reg;
        drop_next     = drop_reg;
        med_out_next  = med_out_reg;
        held_out_next = held_out_reg;
        drop_out_next = drop_out_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = val_reg;
        ram_raddr     = c_idx[HEAP_AW-1:0];

        unique case (cmd.op)
            OP_LOAD:
            begin
                x_next = sample_in;
            end
            OP_DECIDE:
            begin
                drop_next     = stat.full;
                heap_sel_next = sd_heap;
                val_next      = x_reg;
                idx_next      = '0;
                pu_heap_next  = pu_heap;
                pu_val_next   = pu_val;
            end
            OP_SD_CHK:
            begin
                if (stat.sd_leaf)
                    ram_we = 1'b1;
            end
            OP_SD_RDB:
            begin
                ca_next   = rdata;
                ram_raddr = c1_idx[HEAP_AW-1:0];
            end
            OP_SD_CMP:
            begin
                ram_we = 1'b1;
                if (stat.sd_move)
                begin
                    ram_wdata = pick;
                    idx_next  = pick_idx;
                end
            end
            OP_PU_START:
            begin
                heap_sel_next = pu_heap_reg;
                val_next      = pu_val_reg;
                if (pu_heap_reg == HEAP_UP)
                begin
                    idx_next    = up_cnt_reg[HEAP_AW-1:0];
                    up_cnt_next = up_cnt_reg + 1'b1;
                end
                else
                begin
                    idx_next    = lo_cnt_reg[HEAP_AW-1:0];
                    lo_cnt_next = lo_cnt_reg + 1'b1;
                end
            end
            OP_PU_CHK:
            begin
                if (stat.pu_root)
                    ram_we = 1'b1;
                else
                    ram_raddr = parent;
            end
            OP_PU_CMP:
            begin
                ram_we = 1'b1;
                if (stat.pu_move)
                begin
                    ram_wdata = rdata;
                    idx_next  = parent;
                end
            end
            OP_FINISH:
            begin
                if (!drop_reg)
                begin
                    priority if (lo_cnt_reg == up_cnt_reg)
                        med_next = top_sum;
                    else if (lo_cnt_reg > up_cnt_reg)
                        med_next = {lo_top_reg, 1'b0};
                    else
                        med_next = {up_top_reg, 1'b0};
                end
                med_out_next  = drop_reg ? med_reg : med_next;
                held_out_next = HELD_W'(held_sum);
                drop_out_next = drop_reg;
            end
            default:
            begin
            end
        endcase
    end

    // tops follow every write to the root
    always_comb
    begin
        lo_top_next = lo_top_reg;
        up_top_next = up_top_reg;
        if (ram_we && (ram_waddr == '0))
        begin
            if (heap_sel_reg == HEAP_UP)
                up_top_next = ram_wdata;
            else
                lo_top_next = ram_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_cnt_reg <= '0;
            up_cnt_reg <= '0;
            med_reg    <= -(MED_W'(2));
        end
        else
        begin
            lo_cnt_reg <= lo_cnt_next;
            up_cnt_reg <= up_cnt_next;
            med_reg    <= med_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        val_reg      <= val_next;
        ca_reg       <= ca_next;
        pu_val_reg   <= pu_val_next;
        pu_heap_reg  <= pu_heap_next;
        heap_sel_reg <= heap_sel_next;
        idx_reg      <= idx_next;
        drop_reg     <= drop_next;
        lo_top_reg   <= lo_top_next;
        up_top_reg   <= up_top_next;
        med_out_reg  <= med_out_next;
        held_out_reg <= held_out_next;
        drop_out_reg <= drop_out_next;
    end

    assign med_out     = med_out_reg;
    assign held_out    = held_out_reg;
    assign dropped_out = drop_out_reg;

endmodule

// ===== hw/rtl/running_median.sv =====
// Running median over a stream of signed 32-bit samples (two-heap method).
//
// Slave side takes one sample word per handshake (s_tvalid/s_tready).
// Master side returns one word per sample: twice the current median, the
// number of values held and, in m_tuser, a flag that the sample was dropped
// because the store already holds CAPACITY values.
// One sample is in flight at a time; s_tready is high only while idle.
// From accept to m_tvalid the sequencer loads, decides (skipping to finish
// if full), runs a root replacement sift-down (only if a top moves across)
// with a check, a read and a compare per level to a leaf or no move, starts
// a sift-up with a check and a compare per level, then finishes; the heaps
// hold 512 entries. The heap RAMs allow one read and one write per cycle.
// The next sample is taken only after the result word has been handed off.
// The result word holds until m_tready; no new sample is taken meanwhile.
// Reset clears both counts and sets the doubled median to minus two; heap
// RAMs need no clearing since only entries below the counts are read.
module running_median
    import rm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [31:0] sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [32:0] median_doubled, [43:33] held_count
    output logic [0:0]            m_tuser    // [0] dropped
);

`include "running_median_defines.svh"

    rm_cmd_t            cmd;
    rm_stat_t           stat;
    logic [MED_W-1:0]   med;
    logic [HELD_W-1:0]  held;
    logic               dropped;

    rm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    rm_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_in   (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .med_out     (med),
        .held_out    (held),
        .dropped_out (dropped)
    );

    assign m_tdata    = {(OUT_DATA_W-MED_W-HELD_W)'(0), held, med};
    assign m_tuser[0] = dropped;

    `RM_ASSERT_SAME(a_one_in_flight, s_tvalid && s_tready, !m_tvalid)
    `RM_ASSERT_SAME(a_drop_only_full, m_tvalid && m_tuser[0],
        m_tdata[MED_W+HELD_W-1:MED_W] == HELD_W'(CAPACITY))
    `RM_ASSERT_SAME(a_count_bound, m_tvalid,
        m_tdata[MED_W+HELD_W-1:MED_W] <= HELD_W'(CAPACITY))
    `RM_ASSERT_NEXT(a_load_decides, cmd.op == OP_LOAD, cmd.op == OP_DECIDE)

endmodule

// ===== test/tb_top.sv =====
// Testbench for the running median block: random and directed samples, checked against a two-heap predictor.
`timescale 1ns / 1ps
module tb_top;
    import rm_pkg::*;

    typedef struct {
        logic signed [MED_W-1:0] median_doubled;
        logic [HELD_W-1:0]       held_count;
        logic                    dropped;
    } median_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SAMPLE_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0] m_tuser;

    running_median dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #1 clk = ~clk;

    logic signed [SAMPLE_W-1:0] pending_samples[$];
    median_word_t expected_medians[$];
    logic signed [SAMPLE_W-1:0] low_heap[HEAP_DEPTH+2];
    logic signed [SAMPLE_W-1:0] high_heap[HEAP_DEPTH+2];
    int low_n, high_n;
    logic signed [MED_W:0] median_x2;
    int fail_count = 0;
    int accepted = 0;
    int drop_seen = 0;
    int stall_cycles = 0;
    bit quiet = 1'b0;
    bit hold_sender = 1'b0;

    function automatic bit ranks_above(logic signed [SAMPLE_W-1:0] a,
                                       logic signed [SAMPLE_W-1:0] b, bit is_low);
        return is_low ? (a > b) : (a < b);
    endfunction

    task automatic heap_insert(bit is_low, logic signed [SAMPLE_W-1:0] v);
        int i;
        int p;
        i = is_low ? low_n : high_n;
        if (is_low) low_n++; else high_n++;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (ranks_above(v, is_low ? low_heap[p] : high_heap[p], is_low))
            begin
                if (is_low) low_heap[i] = low_heap[p]; else high_heap[i] = high_heap[p];
                i = p;
            end
            else break;
        end
        if (is_low) low_heap[i] = v; else high_heap[i] = v;
    endtask

    task automatic heap_take_top(bit is_low, output logic signed [SAMPLE_W-1:0] top);
        logic signed [SAMPLE_W-1:0] last;
        logic signed [SAMPLE_W-1:0] hc, hc1;
        int i;
        int c;
        int n;
        i = 0;
        if (is_low) begin top = low_heap[0]; low_n--; n = low_n; last = low_heap[n]; end
        else begin top = high_heap[0]; high_n--; n = high_n; last = high_heap[n]; end
        forever begin
            c = 2 * i + 1;
            if (c >= n) break;
            hc = is_low ? low_heap[c] : high_heap[c];
            if (c + 1 < n) begin
                hc1 = is_low ? low_heap[c+1] : high_heap[c+1];
                if (ranks_above(hc1, hc, is_low)) begin c++; hc = hc1; end
            end
            if (ranks_above(hc, last, is_low)) begin
                if (is_low) low_heap[i] = hc; else high_heap[i] = hc;
                i = c;
            end
            else break;
        end
        if (n > 0) begin
            if (is_low) low_heap[i] = last; else high_heap[i] = last;
        end
    endtask

    task automatic predict_median(logic signed [SAMPLE_W-1:0] x);
        logic signed [MED_W:0] x2;
        logic signed [SAMPLE_W-1:0] moved;
        median_word_t w;
        x2 = 2 * $signed({{2{x[SAMPLE_W-1]}}, x});
        w.dropped = 1'b0;
        if (low_n + high_n >= CAPACITY) w.dropped = 1'b1;
        else if (low_n == high_n) begin
            if (x2 > median_x2) begin heap_insert(0, x); median_x2 = 2 * high_heap[0]; end
            else begin heap_insert(1, x); median_x2 = 2 * low_heap[0]; end
        end
        else begin
            if (low_n < high_n) begin
                if (x2 > median_x2) begin
                    heap_insert(0, x);
                    heap_take_top(0, moved);
                    heap_insert(1, moved);
                end
                else heap_insert(1, x);
            end
            else begin
                if (x2 < median_x2) begin
                    heap_insert(1, x);
                    heap_take_top(1, moved);
                    heap_insert(0, moved);
                end
                else heap_insert(0, x);
            end
            median_x2 = low_heap[0] + high_heap[0];
        end
        w.median_doubled = median_x2[MED_W-1:0];
        w.held_count = HELD_W'(low_n + high_n);
        expected_medians.insert(expected_medians.size(), w);
    endtask

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                predict_median($signed(s_tdata));
                accepted++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (pending_samples.size() > 0 && !hold_sender
                    && (quiet || $urandom_range(99) >= 10)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_samples.pop_front();
                end
                else s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        median_word_t got, want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got.median_doubled = $signed(m_tdata[32:0]);
                got.held_count = m_tdata[43:33];
                got.dropped = m_tuser[0];
                drop_seen += got.dropped;
                if (expected_medians.size() == 0) begin
                    $error("unexpected result word %h", m_tdata);
                    fail_count++;
                end
                else begin
                    want = expected_medians.pop_front();
                    if (got.median_doubled !== want.median_doubled) begin
                        $error("median_doubled expected %0d actual %0d",
                               want.median_doubled, got.median_doubled);
                        fail_count++;
                    end
                    if (got.held_count !== want.held_count) begin
                        $error("held_count expected %0d actual %0d",
                               want.held_count, got.held_count);
                        fail_count++;
                    end
                    if (got.dropped !== want.dropped) begin
                        $error("dropped expected %0d actual %0d", want.dropped, got.dropped);
                        fail_count++;
                    end
                end
            end
            m_tready <= quiet || $urandom_range(99) >= 10;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles > 20000) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(20) - 10;
            2: return 32'h7fffffff - $urandom_range(3);
            3: return 32'h80000000 + $urandom_range(3);
            default: return $urandom_range(2000) - 1000;
        endcase
    endfunction

    initial begin
        logic [SAMPLE_W-1:0] directed[$];
        low_n = 0;
        high_n = 0;
        median_x2 = -2;
        directed = '{32'h0, 32'hffffffff, 32'h7fffffff, 32'h80000000, 32'hfffffffe,
                     32'h1, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                     32'h5, 32'h5, 32'hfffffffb, 32'h0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed[i]) pending_samples.insert(pending_samples.size(), directed[i]);
        // fill to capacity and beyond, then keep dropping
        for (int i = 0; i < 1100; i++)
            pending_samples.insert(pending_samples.size(), random_sample());
        wait (pending_samples.size() == 600);
        hold_sender = 1'b1;
        wait (pending_samples.size() == 600 && !s_tvalid && expected_medians.size() == 0
              && accepted == 14 + 500);
        @(posedge clk);
        hold_sender = 1'b0;
        quiet = 1'b1;
        wait (pending_samples.size() == 300);
        quiet = 1'b0;
        wait (pending_samples.size() == 0 && !s_tvalid);
        wait (expected_medians.size() == 0);
        repeat (100) @(posedge clk);
        $display("covered %0d samples, %0d dropped after the store filled",
                 accepted, drop_seen);
        if (fail_count == 0 && expected_medians.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
